### hw/rtl/slfr_pkg.sv
// Package for the sync/length frame receiver.
// Holds the command and register codes, the parser phase type and the structs
// passed between the front parser, the drain unit and the result queue.
package slfr_pkg;

   localparam int FILL_W    = 7;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PW    = 2;
   localparam int RSP_CW    = 3;

   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   localparam logic [2:0] CSR_SYNC_FIRST   = 3'd0;
   localparam logic [2:0] CSR_SYNC_SECOND  = 3'd1;
   localparam logic [2:0] CSR_TAIL_VALUE   = 3'd2;
   localparam logic [2:0] CSR_LENGTH_LIMIT = 3'd3;
   localparam logic [2:0] CSR_GAP_TICKS    = 3'd4;

   localparam logic [7:0]  SYNC_FIRST_RST   = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND_RST  = 8'h55;
   localparam logic [7:0]  TAIL_VALUE_RST   = 8'hFF;
   localparam logic [6:0]  LENGTH_LIMIT_RST = 7'd64;
   localparam logic [15:0] GAP_TICKS_RST    = 16'd10;

   typedef enum logic [9:0] {
      PH_SYNC1 = 10'b00_0000_0001,
      PH_SYNC2 = 10'b00_0000_0010,
      PH_SEQL  = 10'b00_0000_0100,
      PH_SEQH  = 10'b00_0000_1000,
      PH_TYPE  = 10'b00_0001_0000,
      PH_LENL  = 10'b00_0010_0000,
      PH_LENH  = 10'b00_0100_0000,
      PH_BODY  = 10'b00_1000_0000,
      PH_TAIL  = 10'b01_0000_0000,
      PH_DONE  = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [7:0]  tail_value;
      logic [6:0]  length_limit;
      logic [15:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [FILL_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   typedef struct packed {
      logic              valid;
      logic [15:0]       seq;
      logic [7:0]        ftype;
      logic [FILL_W-1:0] len;
   } desc_type;

   typedef struct packed {
      logic [15:0] frame_seq;
      logic [7:0]  frame_type;
      logic [6:0]  frame_len;
      logic        payload_valid;
      logic [5:0]  payload_index;
      logic [7:0]  payload_byte;
      logic        run_last;
   } rsp_item_type;

endpackage

### hw/rtl/sync_length_frame_receiver.sv
// Sync/length frame receiver top level: CSRs, front parser, drain unit and
// result queue. Depends on slfr_pkg, slfr_front, slfr_back, slfr_rsp_fifo.
// Input: one command per cycle while full is low; full rises the cycle after a good
// tail byte and stays high while the finished frame drains, which a slow pop stalls
// by leaving the four-word result queue full. Result words pass the descriptor flag,
// the busy flag and beat register, one per cycle while the queue has room.
// Reset: synchronous; registers to defaults, parser to sync hunt, queues empty;
// the payload memory is not cleared.
module sync_length_frame_receiver #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_frame_seq,
   output logic [7:0]  rsp_frame_type,
   output logic [6:0]  rsp_frame_len,
   output logic        rsp_payload_valid,
   output logic [5:0]  rsp_payload_index,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import slfr_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   wr_type            wr;
   desc_type          desc;
   logic              desc_take;
   logic              back_busy;
   logic              accept;
   logic              q_push;
   rsp_item_type      q_item;
   rsp_item_type      rsp_item;
   logic [RSP_CW-1:0] q_level;

   assign csr_ready = 1'b1;
   assign full      = desc.valid | back_busy;
   assign accept    = push & ~full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:   cfg_in.sync_first   = csr_wdata[7:0];
            CSR_SYNC_SECOND:  cfg_in.sync_second  = csr_wdata[7:0];
            CSR_TAIL_VALUE:   cfg_in.tail_value   = csr_wdata[7:0];
            CSR_LENGTH_LIMIT: cfg_in.length_limit = csr_wdata[6:0];
            CSR_GAP_TICKS:    cfg_in.gap_ticks    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first   <= SYNC_FIRST_RST;
         cfg_ff.sync_second  <= SYNC_SECOND_RST;
         cfg_ff.tail_value   <= TAIL_VALUE_RST;
         cfg_ff.length_limit <= LENGTH_LIMIT_RST;
         cfg_ff.gap_ticks    <= GAP_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .cmd       (req_cmd),
      .data_byte (req_data_byte),
      .desc_take (desc_take),
      .wr        (wr),
      .desc      (desc)
   );

   slfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .desc      (desc),
      .q_level   (q_level),
      .desc_take (desc_take),
      .busy      (back_busy),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   slfr_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_item  (q_item),
      .rd_en    (pop),
      .rd_item  (rsp_item),
      .level    (q_level),
      .is_empty (empty)
   );

   assign rsp_frame_seq     = rsp_item.frame_seq;
   assign rsp_frame_type    = rsp_item.frame_type;
   assign rsp_frame_len     = rsp_item.frame_len;
   assign rsp_payload_valid = rsp_item.payload_valid;
   assign rsp_payload_index = rsp_item.payload_index;
   assign rsp_payload_byte  = rsp_item.payload_byte;
   assign rsp_run_last      = rsp_item.run_last;

   a_no_q_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_level < RSP_CW'(RSP_DEPTH)))
      else $error("result queue overflow");

   a_no_write_while_drain: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (!back_busy && !desc.valid))
      else $error("payload written while a frame drains");

   a_empty_frame_word: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_payload_valid) |-> (rsp_run_last && rsp_frame_len == 7'd0))
      else $error("malformed empty-frame word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

endmodule

### hw/rtl/slfr_front.sv
// Front parser of the frame receiver: takes commands, walks the frame phases,
// writes payload bytes out and hands a descriptor to the drain unit.
// Depends on slfr_pkg.
module slfr_front #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  slfr_pkg::cfg_type cfg,
   input  logic              accept,
   input  logic [1:0]        cmd,
   input  logic [7:0]        data_byte,
   input  logic              desc_take,
   output slfr_pkg::wr_type  wr,
   output slfr_pkg::desc_type desc
);
   import slfr_pkg::*;

   localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

   phase_type         phase_ff, phase_in, cur;
   logic [15:0]       seq_ff, seq_in;
   logic [7:0]        type_ff, type_in;
   logic [15:0]       length_ff, length_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       silence_ff, silence_in;
   logic              locked_ff, locked_in;
   logic              dvalid_ff, dvalid_in;
   logic [15:0]       eff_limit;
   logic [15:0]       len_full;

   assign eff_limit = ({9'd0, cfg.length_limit} > MaxLen) ? MaxLen : {9'd0, cfg.length_limit};
   assign len_full  = {data_byte, length_ff[7:0]};
   assign cur       = (silence_ff == 16'd0) ? PH_SYNC1 : phase_ff;

   always_comb begin
      phase_in   = phase_ff;
      seq_in     = seq_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      fill_in    = fill_ff;
      silence_in = silence_ff;
      locked_in  = locked_ff;
      dvalid_in  = dvalid_ff & ~desc_take;
      wr         = '0;
      if (accept) begin
         unique case (cmd)
            CMD_BYTE: begin
               if (!locked_ff) begin
                  silence_in = (cfg.gap_ticks == 16'd0) ? 16'd1 : cfg.gap_ticks;
                  phase_in   = cur;
                  unique case (cur)
                     PH_SYNC1: begin
                        if (data_byte == cfg.sync_first) phase_in = PH_SYNC2;
                     end
                     PH_SYNC2: begin
                        phase_in = (data_byte == cfg.sync_second) ? PH_SEQL : PH_SYNC1;
                     end
                     PH_SEQL: begin
                        seq_in   = {8'd0, data_byte};
                        phase_in = PH_SEQH;
                     end
                     PH_SEQH: begin
                        seq_in   = {data_byte, seq_ff[7:0]};
                        phase_in = PH_TYPE;
                     end
                     PH_TYPE: begin
                        type_in  = data_byte;
                        phase_in = PH_LENL;
                     end
                     PH_LENL: begin
                        length_in = {8'd0, data_byte};
                        phase_in  = PH_LENH;
                     end
                     PH_LENH: begin
                        length_in = len_full;
                        if (len_full > eff_limit) begin
                           phase_in = PH_SYNC1;
                        end else begin
                           fill_in  = '0;
                           phase_in = (len_full != 16'd0) ? PH_BODY : PH_TAIL;
                        end
                     end
                     PH_BODY: begin
                        wr.en   = 1'b1;
                        wr.addr = fill_ff;
                        wr.data = data_byte;
                        fill_in = fill_ff + 7'd1;
                        if (({9'd0, fill_ff} + 16'd1) >= length_ff) phase_in = PH_TAIL;
                     end
                     PH_TAIL: begin
                        if (data_byte == cfg.tail_value) begin
                           phase_in  = PH_DONE;
                           locked_in = 1'b1;
                           dvalid_in = 1'b1;
                        end else begin
                           phase_in = PH_SYNC1;
                        end
                     end
                     PH_DONE: begin
                     end
                     default: phase_in = PH_SYNC1;
                  endcase
               end
            end
            CMD_TICK: begin
               if (!locked_ff && silence_ff != 16'd0) silence_in = silence_ff - 16'd1;
            end
            CMD_RELEASE: begin
               phase_in   = PH_SYNC1;
               seq_in     = '0;
               type_in    = '0;
               length_in  = '0;
               fill_in    = '0;
               silence_in = '0;
               locked_in  = 1'b0;
            end
            CMD_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC1;
         fill_ff    <= '0;
         silence_ff <= '0;
         locked_ff  <= 1'b0;
         dvalid_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         fill_ff    <= fill_in;
         silence_ff <= silence_in;
         locked_ff  <= locked_in;
         dvalid_ff  <= dvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff    <= seq_in;
      type_ff   <= type_in;
      length_ff <= length_in;
   end

   assign desc.valid = dvalid_ff;
   assign desc.seq   = seq_ff;
   assign desc.ftype = type_ff;
   assign desc.len   = length_ff[FILL_W-1:0];

endmodule

### hw/rtl/slfr_rsp_fifo.sv
// Result queue of the frame receiver: a four-word queue in front of the
// result ports. Depends on slfr_pkg.
module slfr_rsp_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  slfr_pkg::rsp_item_type     wr_item,
   input  logic                       rd_en,
   output slfr_pkg::rsp_item_type     rd_item,
   output logic [slfr_pkg::RSP_CW-1:0] level,
   output logic                       is_empty
);
   import slfr_pkg::*;

   rsp_item_type      slot_ff [RSP_DEPTH];
   logic [RSP_PW-1:0] wp_ff, wp_in;
   logic [RSP_PW-1:0] rp_ff, rp_in;
   logic [RSP_CW-1:0] cnt_ff, cnt_in;
   logic              do_rd;

   assign do_rd = rd_en & (cnt_ff != '0);

   always_comb begin
      wp_in  = wr_en ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_rd ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + RSP_CW'(wr_en) - RSP_CW'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) slot_ff[wp_ff] <= wr_item;
   end

   assign rd_item  = slot_ff[rp_ff];
   assign level    = cnt_ff;
   assign is_empty = (cnt_ff == '0);

endmodule

### hw/rtl/slfr_back.sv
// Drain unit of the frame receiver: holds the payload memory, takes a frame
// descriptor and plays the frame out as result words. Depends on slfr_pkg.
module slfr_back #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  slfr_pkg::wr_type            wr,
   input  slfr_pkg::desc_type          desc,
   input  logic [slfr_pkg::RSP_CW-1:0] q_level,
   output logic                        desc_take,
   output logic                        busy,
   output logic                        q_push,
   output slfr_pkg::rsp_item_type      q_item
);
   import slfr_pkg::*;

   localparam int Depth = (MAX_PAYLOAD < 128) ? MAX_PAYLOAD : 128;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

   logic [7:0]        mem [Depth];
   logic [7:0]        mem_q_ff;

   logic              busy_ff, busy_in;
   logic [FILL_W-1:0] k_ff, k_in;
   logic [FILL_W-1:0] n_ff;
   logic [15:0]       seq_ff;
   logic [7:0]        type_ff;
   logic              beat_ff, beat_in;
   logic              bpv_ff;
   logic [5:0]        bidx_ff;
   logic              blast_ff;
   logic              issue;
   logic              last_k;
   logic [RSP_CW:0]   fill_lvl;

   assign fill_lvl  = {1'b0, q_level} + {{RSP_CW{1'b0}}, beat_ff};
   assign issue     = busy_ff && (fill_lvl < (RSP_CW + 1)'(RSP_DEPTH));
   assign last_k    = (n_ff == '0) || ((k_ff + 7'd1) == n_ff);
   assign desc_take = desc.valid & ~busy_ff;

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      beat_in = issue;
      if (desc_take) begin
         busy_in = 1'b1;
         k_in    = '0;
      end else if (issue) begin
         if (last_k) busy_in = 1'b0;
         else k_in = k_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
         beat_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_take) begin
         n_ff    <= desc.len;
         seq_ff  <= desc.seq;
         type_ff <= desc.ftype;
      end
      if (issue) begin
         bpv_ff   <= (n_ff != '0);
         bidx_ff  <= k_ff[5:0];
         blast_ff <= last_k;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr[AW-1:0]] <= wr.data;
      if (issue) mem_q_ff <= mem[k_ff[AW-1:0]];
   end

   assign busy                 = busy_ff;
   assign q_push               = beat_ff;
   assign q_item.frame_seq     = seq_ff;
   assign q_item.frame_type    = type_ff;
   assign q_item.frame_len     = n_ff;
   assign q_item.payload_valid = bpv_ff;
   assign q_item.payload_index = bpv_ff ? bidx_ff : 6'd0;
   assign q_item.payload_byte  = bpv_ff ? mem_q_ff : 8'd0;
   assign q_item.run_last      = blast_ff;

endmodule

### bench/tb_sync_length_frame_receiver.sv
// Self-checking bench for sync_length_frame_receiver: a directed table, then
// random frames over several register settings, scored against a local parser.
// Depends on slfr_pkg and the RTL of the block only.
module tb_sync_length_frame_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   import slfr_pkg::*;

   localparam int MAX_PAYLOAD    = 64;
   localparam int PHASE_ITEMS    = 56;
   localparam int QUIET_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DIR_ROWS       = 29;

   typedef struct packed {
      logic [1:0]   cmd;
      logic [7:0]   data;
      logic         typed;
      rsp_item_type want;
   } dir_row_type;

   typedef enum int {FLAW_NONE, FLAW_TAIL, FLAW_SYNC, FLAW_LENGTH, FLAW_SILENCE} flaw_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_cmd;
   logic [7:0]  req_data_byte;
   logic        empty;
   logic        pop;
   logic [15:0] rsp_frame_seq;
   logic [7:0]  rsp_frame_type;
   logic [6:0]  rsp_frame_len;
   logic        rsp_payload_valid;
   logic [5:0]  rsp_payload_index;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_run_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   sync_length_frame_receiver #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_top (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_cmd(req_cmd),
      .req_data_byte(req_data_byte),
      .empty(empty),
      .pop(pop),
      .rsp_frame_seq(rsp_frame_seq),
      .rsp_frame_type(rsp_frame_type),
      .rsp_frame_len(rsp_frame_len),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_payload_index(rsp_payload_index),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_run_last(rsp_run_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // parser copy
   cfg_type      p_cfg;
   phase_type    p_phase;
   logic [15:0]  p_seq;
   logic [7:0]   p_type;
   logic [15:0]  p_len;
   logic [6:0]   p_fill;
   logic [7:0]   p_store [MAX_PAYLOAD];
   logic [15:0]  p_silence;
   logic         p_locked;

   rsp_item_type expected_words [$];
   int           items_sent;
   int           frames_done;
   int           words_checked;
   int           settings_applied;
   int           errors;
   int           quiet_cycles;
   bit           req_calm;

   function automatic dir_row_type plain_row(logic [1:0] c, logic [7:0] d);
      dir_row_type r;
      r = '0;
      r.cmd = c;
      r.data = d;
      return r;
   endfunction

   function automatic dir_row_type checked_row(logic [1:0] c, logic [7:0] d, logic [15:0] seq,
                                                logic [7:0] ftype, logic [6:0] len, logic pv,
                                                logic [5:0] idx, logic [7:0] pbyte, logic last);
      dir_row_type r;
      r.cmd = c;
      r.data = d;
      r.typed = 1'b1;
      r.want.frame_seq = seq;
      r.want.frame_type = ftype;
      r.want.frame_len = len;
      r.want.payload_valid = pv;
      r.want.payload_index = idx;
      r.want.payload_byte = pbyte;
      r.want.run_last = last;
      return r;
   endfunction

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      plain_row(CMD_NONE, 8'hFF),
      // empty frame under reset settings
      plain_row(CMD_BYTE, 8'hAA), plain_row(CMD_BYTE, 8'h55),
      plain_row(CMD_BYTE, 8'h34), plain_row(CMD_BYTE, 8'h12),
      plain_row(CMD_BYTE, 8'h7E), plain_row(CMD_BYTE, 8'h00),
      plain_row(CMD_BYTE, 8'h00),
      checked_row(CMD_BYTE, 8'hFF, 16'h1234, 8'h7E, 7'd0, 1'b0, 6'd0, 8'h00, 1'b1),
      plain_row(CMD_TICK, 8'h00), plain_row(CMD_RELEASE, 8'hFF),
      // bad second sync
      plain_row(CMD_BYTE, 8'hAA), plain_row(CMD_BYTE, 8'h00),
      // length 256 rejected
      plain_row(CMD_BYTE, 8'hAA), plain_row(CMD_BYTE, 8'h55),
      plain_row(CMD_BYTE, 8'hFF), plain_row(CMD_BYTE, 8'hFF),
      plain_row(CMD_BYTE, 8'hFF), plain_row(CMD_BYTE, 8'h00),
      plain_row(CMD_BYTE, 8'h01),
      // one-byte frame, sequence, type and payload byte at their top
      plain_row(CMD_BYTE, 8'hAA), plain_row(CMD_BYTE, 8'h55),
      plain_row(CMD_BYTE, 8'hFF), plain_row(CMD_BYTE, 8'hFF),
      plain_row(CMD_BYTE, 8'hFF), plain_row(CMD_BYTE, 8'h01),
      plain_row(CMD_BYTE, 8'h00), plain_row(CMD_BYTE, 8'hFF),
      checked_row(CMD_BYTE, 8'hFF, 16'hFFFF, 8'hFF, 7'd1, 1'b1, 6'd0, 8'hFF, 1'b1)
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic step_parser(input logic [1:0] cmd, input logic [7:0] b);
      rsp_item_type w;
      logic [15:0]  lim;
      case (cmd)
         CMD_BYTE: begin
            if (!p_locked) begin
               if (p_silence == 16'd0) p_phase = PH_SYNC1;
               p_silence = (p_cfg.gap_ticks == 16'd0) ? 16'd1 : p_cfg.gap_ticks;
               lim = (p_cfg.length_limit > 7'd64) ? 16'd64 : {9'd0, p_cfg.length_limit};
               case (p_phase)
                  PH_SYNC1: if (b == p_cfg.sync_first) p_phase = PH_SYNC2;
                  PH_SYNC2: p_phase = (b == p_cfg.sync_second) ? PH_SEQL : PH_SYNC1;
                  PH_SEQL: begin
                     p_seq = {8'h00, b};
                     p_phase = PH_SEQH;
                  end
                  PH_SEQH: begin
                     p_seq = {b, p_seq[7:0]};
                     p_phase = PH_TYPE;
                  end
                  PH_TYPE: begin
                     p_type = b;
                     p_phase = PH_LENL;
                  end
                  PH_LENL: begin
                     p_len = {8'h00, b};
                     p_phase = PH_LENH;
                  end
                  PH_LENH: begin
                     p_len = {b, p_len[7:0]};
                     if (p_len > lim) begin
                        p_phase = PH_SYNC1;
                     end else begin
                        p_fill = 7'd0;
                        p_phase = (p_len != 16'd0) ? PH_BODY : PH_TAIL;
                     end
                  end
                  PH_BODY: begin
                     if (p_fill < 7'd64) p_store[p_fill[5:0]] = b;
                     p_fill = p_fill + 7'd1;
                     if ({9'd0, p_fill} >= p_len) p_phase = PH_TAIL;
                  end
                  PH_TAIL: begin
                     if (b == p_cfg.tail_value) begin
                        p_phase = PH_DONE;
                        p_locked = 1'b1;
                        frames_done++;
                        w.frame_seq = p_seq;
                        w.frame_type = p_type;
                        if (p_len == 16'd0) begin
                           w.frame_len = 7'd0;
                           w.payload_valid = 1'b0;
                           w.payload_index = 6'd0;
                           w.payload_byte = 8'h00;
                           w.run_last = 1'b1;
                           expected_words.push_back(w);
                        end
                        for (int k = 0; k < int'(p_len) && k < MAX_PAYLOAD; k++) begin
                           w.frame_len = p_len[6:0];
                           w.payload_valid = 1'b1;
                           w.payload_index = 6'(k);
                           w.payload_byte = p_store[k];
                           w.run_last = (k + 1 == int'(p_len));
                           expected_words.push_back(w);
                        end
                     end else begin
                        p_phase = PH_SYNC1;
                     end
                  end
                  PH_DONE: ;
                  default: p_phase = PH_SYNC1;
               endcase
            end
         end
         CMD_TICK: if (!p_locked && p_silence != 16'd0) p_silence = p_silence - 16'd1;
         CMD_RELEASE: begin
            p_phase = PH_SYNC1;
            p_seq = '0;
            p_type = '0;
            p_len = '0;
            p_fill = '0;
            p_silence = '0;
            p_locked = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic drive_word(input logic [1:0] cmd, input logic [7:0] data);
      int gap;
      gap = req_calm ? 0 : int'($urandom_range(0, 18));
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_cmd <= cmd;
      req_data_byte <= data;
      @(posedge clock);
      while (full) @(posedge clock);
      if (cmd == CMD_RELEASE || !p_locked) items_sent++;
      step_parser(cmd, data);
   endtask

   task automatic send_frame(input flaw_type flaw);
      logic [9:0] words [$];
      int         lim;
      int         len;
      int         gap_eff;
      int         cut;
      logic [7:0] lo;
      logic [7:0] hi;
      lim = (int'(p_cfg.length_limit) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(p_cfg.length_limit);
      gap_eff = (p_cfg.gap_ticks == 16'd0) ? 1 : int'(p_cfg.gap_ticks);
      if ($urandom_range(0, 9) == 0) len = lim;
      else len = int'($urandom_range(0, (lim < 6) ? lim : 6));
      lo = 8'(len);
      hi = 8'h00;
      if (flaw == FLAW_LENGTH) begin
         if (lim < 255 && $urandom_range(0, 1) == 1) begin
            lo = 8'($urandom_range(lim + 1, 255));
         end else begin
            lo = 8'($urandom);
            hi = 8'($urandom_range(1, 255));
         end
      end
      if (p_locked || p_phase != PH_SYNC1) words.push_back({CMD_RELEASE, 8'($urandom)});
      words.push_back({CMD_BYTE, p_cfg.sync_first});
      if (flaw == FLAW_SYNC)
         words.push_back({CMD_BYTE, p_cfg.sync_second ^ 8'($urandom_range(1, 255))});
      else
         words.push_back({CMD_BYTE, p_cfg.sync_second});
      repeat (3) words.push_back({CMD_BYTE, 8'($urandom)});
      words.push_back({CMD_BYTE, lo});
      words.push_back({CMD_BYTE, hi});
      for (int k = 0; k < len; k++) begin
         words.push_back({CMD_BYTE, 8'($urandom)});
         if (gap_eff >= 3 && $urandom_range(0, 7) == 0) words.push_back({CMD_TICK, 8'($urandom)});
      end
      if (flaw == FLAW_TAIL)
         words.push_back({CMD_BYTE, p_cfg.tail_value ^ 8'($urandom_range(1, 255))});
      else
         words.push_back({CMD_BYTE, p_cfg.tail_value});
      if (flaw == FLAW_SILENCE && gap_eff <= 40) begin
         cut = int'($urandom_range(1, words.size() - 2));
         repeat (gap_eff) words.insert(cut, {CMD_TICK, 8'($urandom)});
      end
      foreach (words[i]) drive_word(words[i][9:8], words[i][7:0]);
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SYNC_FIRST:   p_cfg.sync_first = val[7:0];
         CSR_SYNC_SECOND:  p_cfg.sync_second = val[7:0];
         CSR_TAIL_VALUE:   p_cfg.tail_value = val[7:0];
         CSR_LENGTH_LIMIT: p_cfg.length_limit = val[6:0];
         CSR_GAP_TICKS:    p_cfg.gap_ticks = val;
         default: ;
      endcase
   endtask

   task automatic load_settings(input cfg_type c);
      write_reg(CSR_SYNC_FIRST, {8'h00, c.sync_first});
      write_reg(CSR_SYNC_SECOND, {8'h00, c.sync_second});
      write_reg(CSR_TAIL_VALUE, {8'h00, c.tail_value});
      write_reg(CSR_LENGTH_LIMIT, {9'd0, c.length_limit});
      write_reg(CSR_GAP_TICKS, c.gap_ticks);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   // result side
   initial begin
      int           gap;
      bit           calm;
      rsp_item_type want;
      calm = 1'b0;
      pop = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) calm = !calm;
         gap = calm ? 0 : int'($urandom_range(0, 18));
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         if (expected_words.size() == 0) begin
            $display("%0t: result word with none expected, seq 0x%0h index %0d byte 0x%0h",
                     $time, rsp_frame_seq, rsp_payload_index, rsp_payload_byte);
            errors++;
         end else begin
            want = expected_words.pop_front();
            compare_field("frame_seq", want.frame_seq, rsp_frame_seq);
            compare_field("frame_type", {8'h00, want.frame_type}, {8'h00, rsp_frame_type});
            compare_field("frame_len", {9'd0, want.frame_len}, {9'd0, rsp_frame_len});
            compare_field("payload_valid", {15'd0, want.payload_valid},
                          {15'd0, rsp_payload_valid});
            compare_field("payload_index", {10'd0, want.payload_index},
                          {10'd0, rsp_payload_index});
            compare_field("payload_byte", {8'h00, want.payload_byte}, {8'h00, rsp_payload_byte});
            compare_field("run_last", {15'd0, want.run_last}, {15'd0, rsp_run_last});
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d result words outstanding",
                     $time, WATCHDOG_LIMIT, expected_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int      pick;
      int      mark;
      cfg_type c;
      reset = 1'b1;
      push = 1'b0;
      req_cmd = CMD_BYTE;
      req_data_byte = 8'h00;
      csr_valid = 1'b0;
      csr_index = CSR_SYNC_FIRST;
      csr_wdata = 16'h0000;
      quiet_cycles = 0;
      items_sent = 0;
      frames_done = 0;
      words_checked = 0;
      settings_applied = 0;
      errors = 0;
      req_calm = 1'b0;
      p_cfg = '{SYNC_FIRST_RST, SYNC_SECOND_RST, TAIL_VALUE_RST, LENGTH_LIMIT_RST,
                GAP_TICKS_RST};
      p_phase = PH_SYNC1;
      p_seq = '0;
      p_type = '0;
      p_len = '0;
      p_fill = '0;
      p_silence = '0;
      p_locked = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         drive_word(DIR_TABLE[r].cmd, DIR_TABLE[r].data);
         if (DIR_TABLE[r].typed) expected_words[$] = DIR_TABLE[r].want;
      end

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            wait_idle();
            case (ph)
               1: c = '{8'h00, 8'hFF, 8'h00, 7'd0, 16'd0};
               2: c = '{8'hFF, 8'h00, 8'hAA, 7'd64, 16'hFFFF};
               default: begin
                  c.sync_first = 8'($urandom);
                  c.sync_second = 8'($urandom);
                  c.tail_value = 8'($urandom);
                  c.length_limit = 7'($urandom_range(0, 64));
                  c.gap_ticks = 16'($urandom_range(1, 24));
               end
            endcase
            load_settings(c);
         end
         mark = items_sent;
         while (items_sent - mark < PHASE_ITEMS) begin
            req_calm = ($urandom_range(0, 3) == 0);
            pick = int'($urandom_range(0, 99));
            if (p_locked) begin
               if (pick < 30)
                  repeat ($urandom_range(1, 4)) drive_word(2'($urandom_range(0, 3)), 8'($urandom));
               drive_word(CMD_RELEASE, 8'($urandom));
            end else if (pick < 60) begin
               send_frame(FLAW_NONE);
            end else if (pick < 68) begin
               send_frame(FLAW_TAIL);
            end else if (pick < 76) begin
               send_frame(FLAW_SYNC);
            end else if (pick < 84) begin
               send_frame(FLAW_LENGTH);
            end else if (pick < 90) begin
               send_frame(FLAW_SILENCE);
            end else begin
               repeat ($urandom_range(1, 6)) drive_word(2'($urandom_range(0, 3)), 8'($urandom));
            end
         end
      end

      wait_idle();
      $display("Sent %0d request words under %0d register settings plus reset values.",
               items_sent, settings_applied);
      $display("Parsed %0d complete frames and checked %0d result words.",
               frames_done, words_checked);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
